[design/atp_pkg.sv]
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types and constants for the archive table-of-contents parser.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int unsigned LEN_W      = 31;  // archive offsets and lengths
  localparam int unsigned PLEN_W     = 8;   // entry path length
  localparam int unsigned BLEN_W     = 24;  // entry body length
  localparam int unsigned MIN_HEADER = 20;  // fixed header part, in bytes
  localparam int unsigned ENTRY_SIZE = 4;   // bytes per table entry

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MAGIC,
    PH_HEADER,
    PH_SKIP,
    PH_TABLE,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    ST_ENTRY,
    ST_DONE,
    ST_SHORT,
    ST_MAGIC,
    ST_GEOM,
    ST_OVERRUN
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [LEN_W-1:0]    path_offset;
    logic [PLEN_W-1:0]   path_length;
    logic [LEN_W-1:0]    body_offset;
    logic [BLEN_W-1:0]   body_length;
  } result_t;

  // Archive signature, byte by byte
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hFF;
      2'd1:    b = 8'h0E;
      2'd2:    b = 8'h67;
      default: b = 8'h67;
    endcase
    return b;
  endfunction

endpackage

[design/atp_core.sv]
// ----------------------------------------------------------------------------
// atp_core
// Parse state and per-byte decode: magic check, header lengths, geometry
// check, header skip and table entry decode. One byte per step.
// ----------------------------------------------------------------------------
module atp_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  data_byte,
  input  logic                        first,
  input  logic [atp_pkg::LEN_W-1:0]   archive_length,
  output logic                        res_valid,
  output atp_pkg::result_t            res
);

  localparam int unsigned LW = atp_pkg::LEN_W;

  atp_pkg::phase_t phase_r, phase_nxt, ph_e;

  logic [LW-1:0]  cnt_r, cnt_nxt, cnt_e;     // archive offset (header and skip)
  logic [23:0]    hw_r, hw_nxt, hw_e;        // partial big-endian word
  logic [LW-1:0]  hl_r, hl_nxt, hl_e;        // header length
  logic [LW-1:0]  tl_r, tl_nxt, tl_e;        // table length
  logic [LW-1:0]  prl_r, prl_nxt, prl_e;     // path region length
  logic [LW-1:0]  brl_r, brl_nxt, brl_e;     // body region length
  logic [LW:0]    p0_r, p0_nxt, p0_e;        // path region start
  logic [LW+1:0]  b0_r, b0_nxt, b0_e;        // body region start
  logic [LW-1:0]  pc_r, pc_nxt, pc_e;        // path bytes used
  logic [LW-1:0]  bc_r, bc_nxt, bc_e;        // body bytes used
  logic [LW-1:0]  eb_r, eb_nxt, eb_e;        // table bytes consumed

  logic [31:0]    word;
  logic [LW+2:0]  b_end;
  logic           geom_bad;
  logic [7:0]     plen;
  logic [23:0]    blen;
  logic [LW:0]    p_end;
  logic [LW:0]    bd_end;
  logic [LW:0]    eb_next_end;

  // A first byte sees a freshly cleared parse
  assign ph_e  = first ? atp_pkg::PH_MAGIC : phase_r;
  assign cnt_e = first ? '0 : cnt_r;
  assign hw_e  = first ? '0 : hw_r;
  assign hl_e  = first ? '0 : hl_r;
  assign tl_e  = first ? '0 : tl_r;
  assign prl_e = first ? '0 : prl_r;
  assign brl_e = first ? '0 : brl_r;
  assign p0_e  = first ? '0 : p0_r;
  assign b0_e  = first ? '0 : b0_r;
  assign pc_e  = first ? '0 : pc_r;
  assign bc_e  = first ? '0 : bc_r;
  assign eb_e  = first ? '0 : eb_r;

  assign word = {hw_e, data_byte};
  assign plen = word[31:24];
  assign blen = word[23:0];

  // Regions must fit in order: table end, path end and body end within the archive
  assign b_end    = {1'b0, b0_e} + {3'b000, word[LW-1:0]};
  assign geom_bad = (hl_e < LW'(atp_pkg::MIN_HEADER))
                 || (p0_e > {1'b0, archive_length})
                 || (b0_e > {2'b00, archive_length})
                 || (b_end > {3'b000, archive_length});

  assign p_end       = {1'b0, pc_e} + {{(LW+1-8){1'b0}}, plen};
  assign bd_end      = {1'b0, bc_e} + {{(LW+1-24){1'b0}}, blen};
  assign eb_next_end = {1'b0, eb_nxt} + (LW+1)'(atp_pkg::ENTRY_SIZE);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    hw_nxt    = hw_r;
    hl_nxt    = hl_r;
    tl_nxt    = tl_r;
    prl_nxt   = prl_r;
    brl_nxt   = brl_r;
    p0_nxt    = p0_r;
    b0_nxt    = b0_r;
    pc_nxt    = pc_r;
    bc_nxt    = bc_r;
    eb_nxt    = eb_r;
    res_valid = 1'b0;
    res       = '{status: atp_pkg::ST_ENTRY, default: '0};

    if (step) begin
      phase_nxt = ph_e;
      cnt_nxt   = cnt_e;
      hw_nxt    = hw_e;
      hl_nxt    = hl_e;
      tl_nxt    = tl_e;
      prl_nxt   = prl_e;
      brl_nxt   = brl_e;
      p0_nxt    = p0_e;
      b0_nxt    = b0_e;
      pc_nxt    = pc_e;
      bc_nxt    = bc_e;
      eb_nxt    = eb_e + LW'(1);

      if (first && (archive_length < LW'(atp_pkg::MIN_HEADER))) begin
        phase_nxt  = atp_pkg::PH_HALT;
        res_valid  = 1'b1;
        res.status = atp_pkg::ST_SHORT;
        eb_nxt     = eb_e;
      end else begin
        unique case (ph_e)
          atp_pkg::PH_MAGIC: begin
            eb_nxt  = eb_e;
            cnt_nxt = cnt_e + LW'(1);
            if (data_byte != atp_pkg::magic_byte(cnt_e[1:0])) begin
              phase_nxt  = atp_pkg::PH_HALT;
              res_valid  = 1'b1;
              res.status = atp_pkg::ST_MAGIC;
            end else if (cnt_e[1:0] == 2'd3) begin
              phase_nxt = atp_pkg::PH_HEADER;
            end
          end

          atp_pkg::PH_HEADER: begin
            eb_nxt  = eb_e;
            cnt_nxt = cnt_e + LW'(1);
            hw_nxt  = word[23:0];
            if (cnt_e[1:0] == 2'd3) begin
              hw_nxt = '0;
              if (word[31]) begin
                phase_nxt  = atp_pkg::PH_HALT;
                res_valid  = 1'b1;
                res.status = atp_pkg::ST_GEOM;
              end else begin
                unique case (cnt_e[3:2])
                  2'd1: hl_nxt = word[LW-1:0];
                  2'd2: begin
                    tl_nxt = word[LW-1:0];
                    p0_nxt = {1'b0, hl_e} + {1'b0, word[LW-1:0]};
                  end
                  2'd3: begin
                    prl_nxt = word[LW-1:0];
                    b0_nxt  = {1'b0, p0_e} + {2'b00, word[LW-1:0]};
                  end
                  default: begin
                    // last header length completes the fixed header
                    brl_nxt = word[LW-1:0];
                    if (geom_bad) begin
                      phase_nxt  = atp_pkg::PH_HALT;
                      res_valid  = 1'b1;
                      res.status = atp_pkg::ST_GEOM;
                    end else if (tl_e < LW'(atp_pkg::ENTRY_SIZE)) begin
                      phase_nxt  = atp_pkg::PH_HALT;
                      res_valid  = 1'b1;
                      res.status = atp_pkg::ST_DONE;
                    end else if (hl_e == LW'(atp_pkg::MIN_HEADER)) begin
                      phase_nxt = atp_pkg::PH_TABLE;
                    end else begin
                      phase_nxt = atp_pkg::PH_SKIP;
                    end
                  end
                endcase
              end
            end
          end

          atp_pkg::PH_SKIP: begin
            eb_nxt  = eb_e;
            cnt_nxt = cnt_e + LW'(1);
            if (cnt_nxt >= hl_e) begin
              phase_nxt = atp_pkg::PH_TABLE;
            end
          end

          atp_pkg::PH_TABLE: begin
            hw_nxt = word[23:0];
            if (eb_nxt[1:0] == 2'd0) begin
              hw_nxt          = '0;
              res_valid       = 1'b1;
              res.path_offset = p0_e[LW-1:0] + pc_e;
              res.path_length = plen;
              res.body_offset = b0_e[LW-1:0] + bc_e;
              res.body_length = blen;
              if ((p_end > {1'b0, prl_e}) || (bd_end > {1'b0, brl_e})) begin
                phase_nxt  = atp_pkg::PH_HALT;
                res.status = atp_pkg::ST_OVERRUN;
              end else begin
                pc_nxt = p_end[LW-1:0];
                bc_nxt = bd_end[LW-1:0];
                if (eb_next_end > {1'b0, tl_e}) begin
                  phase_nxt  = atp_pkg::PH_HALT;
                  res.status = atp_pkg::ST_DONE;
                end else begin
                  res.status = atp_pkg::ST_ENTRY;
                end
              end
            end
          end

          default: begin
            // idle or halted: byte ignored
            eb_nxt = eb_e;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= atp_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    hw_r  <= hw_nxt;
    hl_r  <= hl_nxt;
    tl_r  <= tl_nxt;
    prl_r <= prl_nxt;
    brl_r <= brl_nxt;
    p0_r  <= p0_nxt;
    b0_r  <= b0_nxt;
    pc_r  <= pc_nxt;
    bc_r  <= bc_nxt;
    eb_r  <= eb_nxt;
  end

endmodule

[design/archive_toc_parser.sv]
// ----------------------------------------------------------------------------
// archive_toc_parser
// Streaming archive table-of-contents parser: checks the archive signature
// and header geometry, then reports absolute path and body extents per entry.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | data_byte, first
//  out_    | output    | out_valid/out_ready | status, path/body offset+length
//  cfg_    | input     | cfg_wr_en           | archive_length (31 bits)
//
//  One byte per cycle while in_ready is high; each byte's transaction yields
//  its result (if any) in the output register on the following cycle.
//  The output register is the only buffer: a new byte is taken whenever it
//  is empty or being drained in the same cycle.
//  Synchronous active-low reset puts the parser in idle, awaiting a first byte.
// ----------------------------------------------------------------------------
module archive_toc_parser (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_first,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [atp_pkg::LEN_W-1:0]    out_path_offset,
  output logic [atp_pkg::PLEN_W-1:0]   out_path_length,
  output logic [atp_pkg::LEN_W-1:0]    out_body_offset,
  output logic [atp_pkg::BLEN_W-1:0]   out_body_length,

  input  logic                         cfg_wr_en,
  input  logic [atp_pkg::LEN_W-1:0]    cfg_wr_data
);

  logic [atp_pkg::LEN_W-1:0] archive_length_r;
  logic                      out_valid_r;
  atp_pkg::result_t          out_res_r;
  logic                      in_fire;
  logic                      res_valid;
  atp_pkg::result_t          res;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      archive_length_r <= '0;
    end else if (cfg_wr_en) begin
      archive_length_r <= cfg_wr_data;
    end
  end

  atp_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (in_fire),
    .data_byte      (in_data_byte),
    .first          (in_first),
    .archive_length (archive_length_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_path_offset = out_res_r.path_offset;
  assign out_path_length = out_res_r.path_length;
  assign out_body_offset = out_res_r.body_offset;
  assign out_body_length = out_res_r.body_length;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for archive_toc_parser. Streams directed and random archives in
// byte by byte, mostly well formed with random content, some corrupted,
// truncated or mixed with noise. A scoreboard tracks the parse and checks
// every reported entry and status field by field, with random gaps on the
// input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb;
  import atp_pkg::*;

  localparam bit [31:0]      SIGNATURE = 32'hFF0E6767;
  localparam bit [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_data_byte;
  logic                in_first;
  logic                out_valid;
  logic                out_ready;
  logic [2:0]          out_status;
  logic [LEN_W-1:0]    out_path_offset;
  logic [PLEN_W-1:0]   out_path_length;
  logic [LEN_W-1:0]    out_body_offset;
  logic [BLEN_W-1:0]   out_body_length;
  logic                cfg_wr_en;
  logic [LEN_W-1:0]    cfg_wr_data;

  bit                  gaps_on;
  int                  bytes_sent;
  bit [7:0]            archive_bytes[$];

  class toc_scoreboard;
    bit [LEN_W-1:0] archive_length;
    phase_t         phase;
    bit [31:0]      byte_count;
    bit [31:0]      shift_word;
    bit [31:0]      header_len;
    bit [31:0]      table_len;
    bit [31:0]      path_region;
    bit [31:0]      body_region;
    bit [31:0]      path_used;
    bit [31:0]      body_used;
    bit [31:0]      entry_bytes;
    result_t        expected_entries[$];
    int             errors;

    function new();
      archive_length = '0;
      phase = PH_IDLE;
      errors = 0;
      restart();
    endfunction

    function void restart();
      byte_count = 0;
      shift_word = 0;
      header_len = 0;
      table_len = 0;
      path_region = 0;
      body_region = 0;
      path_used = 0;
      body_used = 0;
      entry_bytes = 0;
    endfunction

    function void set_length(bit [LEN_W-1:0] value);
      archive_length = value;
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction

    function void expect_result(status_t st, bit [31:0] po, bit [31:0] pl,
                                bit [31:0] bo, bit [31:0] bl);
      result_t r;
      r.status      = st;
      r.path_offset = po[LEN_W-1:0];
      r.path_length = pl[PLEN_W-1:0];
      r.body_offset = bo[LEN_W-1:0];
      r.body_length = bl[BLEN_W-1:0];
      expected_entries.push_back(r);
    endfunction

    function void stop_with(status_t st);
      phase = PH_HALT;
      expect_result(st, 0, 0, 0, 0);
    endfunction

    // Returns 1 when the byte took part in a parse, 0 when it was ignored
    function bit note_byte(bit [7:0] b, bit first);
      bit [31:0] pos;
      bit [1:0]  slot;
      bit [31:0] plen;
      bit [31:0] blen;
      bit [31:0] path_base;
      bit [31:0] body_base;
      bit [31:0] po;
      bit [31:0] bo;
      longint    len;
      longint    hl;
      longint    tl;
      longint    prl;
      longint    brl;
      longint    pu;
      longint    bu;
      longint    pl_l;
      longint    bl_l;
      longint    eb;
      if (first) begin
        restart();
        phase = PH_MAGIC;
        if (archive_length < MIN_HEADER) begin
          stop_with(ST_SHORT);
          return 1;
        end
      end
      if (phase == PH_IDLE || phase == PH_HALT) return 0;
      pos = byte_count;
      byte_count++;
      case (phase)
        PH_MAGIC: begin
          if (b != SIGNATURE[31 - 8 * pos[1:0] -: 8]) stop_with(ST_MAGIC);
          else if (pos >= 3) phase = PH_HEADER;
        end
        PH_HEADER: begin
          shift_word = {shift_word[23:0], b};
          if (pos[1:0] == 2'd3) begin
            slot = 2'((pos - 4) >> 2);
            // a length with its top bit set counts as negative
            if (shift_word[31]) begin
              stop_with(ST_GEOM);
              return 1;
            end
            case (slot)
              2'd0:    header_len = shift_word;
              2'd1:    table_len = shift_word;
              2'd2:    path_region = shift_word;
              default: body_region = shift_word;
            endcase
            shift_word = 0;
          end
          if (pos >= 19) begin
            len = archive_length;
            hl  = header_len;
            tl  = table_len;
            prl = path_region;
            brl = body_region;
            if (header_len < MIN_HEADER || hl > len - tl || hl + tl > len - prl ||
                hl + tl + prl > len - brl)
              stop_with(ST_GEOM);
            else if (table_len < ENTRY_SIZE)
              stop_with(ST_DONE);
            else
              phase = (header_len == MIN_HEADER) ? PH_TABLE : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (byte_count >= header_len) phase = PH_TABLE;
        end
        default: begin
          shift_word = {shift_word[23:0], b};
          entry_bytes++;
          if (entry_bytes[1:0] == 2'd0) begin
            plen      = {24'b0, shift_word[31:24]};
            blen      = {8'b0, shift_word[23:0]};
            path_base = header_len + table_len;
            body_base = path_base + path_region;
            po        = path_base + path_used;
            bo        = body_base + body_used;
            shift_word = 0;
            pu   = path_used;
            bu   = body_used;
            prl  = path_region;
            brl  = body_region;
            pl_l = plen;
            bl_l = blen;
            if (pu > prl - pl_l || bu > brl - bl_l) begin
              phase = PH_HALT;
              expect_result(ST_OVERRUN, po, plen, bo, blen);
            end else begin
              path_used += plen;
              body_used += blen;
              eb = entry_bytes;
              tl = table_len;
              // last whole entry reports done itself
              if (eb + ENTRY_SIZE > tl) begin
                phase = PH_HALT;
                expect_result(ST_DONE, po, plen, bo, blen);
              end else begin
                expect_result(ST_ENTRY, po, plen, bo, blen);
              end
            end
          end
        end
      endcase
      return 1;
    endfunction

    function void compare_field(string name, bit [31:0] want, bit [31:0] got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_entries.size() == 0) begin
        $error("status: expected no transaction, got %0d", got.status);
        errors++;
        return;
      end
      want = expected_entries.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("path_offset", want.path_offset, got.path_offset);
      compare_field("path_length", want.path_length, got.path_length);
      compare_field("body_offset", want.body_offset, got.body_offset);
      compare_field("body_length", want.body_length, got.body_length);
    endfunction
  endclass

  toc_scoreboard sb;

  archive_toc_parser i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_first        (in_first),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_path_offset (out_path_offset),
    .out_path_length (out_path_length),
    .out_body_offset (out_body_offset),
    .out_body_length (out_body_length),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_byte(input bit [7:0] b, input bit first);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_first     <= first;
    do @(posedge clk); while (!in_ready);
    void'(sb.note_byte(b, first));
    bytes_sent++;
  endtask

  task automatic send_archive();
    foreach (archive_bytes[i]) send_byte(archive_bytes[i], i == 0);
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // Let every expected transaction arrive before touching the register
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input bit [LEN_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_length(value);
  endtask

  // Builds an archive prefix (signature, header, skipped bytes,
  // table) into archive_bytes; need is the smallest archive length that fits
  task automatic build_archive(input bit fill_max, output bit [31:0] need);
    bit [31:0] words[4];
    bit [7:0]  table_bytes[$];
    bit [31:0] ptot;
    bit [31:0] btot;
    bit [7:0]  plen;
    bit [23:0] blen;
    int        n;
    int        partial;
    archive_bytes.delete();
    ptot = 0;
    btot = 0;
    words[0] = ($urandom_range(0, 3) == 0) ? 20 + $urandom_range(1, 12) : 20;
    if ($urandom_range(0, 19) == 0) words[0] = $urandom_range(0, 19);
    n       = $urandom_range(0, 8);
    partial = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    words[1] = 4 * n + partial;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       plen = 8'hFF;
        1:       plen = 8'h00;
        2:       plen = 8'($urandom);
        default: plen = 8'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 7))
        0:       blen = 24'hFFFFFF;
        1:       blen = 24'h0;
        2:       blen = 24'($urandom);
        default: blen = 24'($urandom_range(0, 4096));
      endcase
      ptot += plen;
      btot += blen;
      table_bytes.push_back(plen);
      table_bytes.push_back(blen[23:16]);
      table_bytes.push_back(blen[15:8]);
      table_bytes.push_back(blen[7:0]);
    end
    repeat (partial) table_bytes.push_back(8'($urandom));
    words[2] = ptot + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : 0);
    if (ptot > 0 && $urandom_range(0, 5) == 0) words[2] = ptot - $urandom_range(1, ptot);
    words[3] = btot + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : 0);
    if (btot > 0 && $urandom_range(0, 5) == 0) words[3] = btot - $urandom_range(1, btot);
    if (fill_max) begin
      // push the body region out to the very end of the largest archive
      words[2] += $urandom_range(0, 1 << 28);
      words[3] = LEN_MAX - (words[0] + words[1] + words[2]);
    end
    need = words[0] + words[1] + words[2] + words[3];
    for (int s = 3; s >= 0; s--) archive_bytes.push_back(SIGNATURE[8*s +: 8]);
    foreach (words[i])
      for (int s = 3; s >= 0; s--) archive_bytes.push_back(words[i][8*s +: 8]);
    for (int k = 20; k < int'(words[0]); k++) archive_bytes.push_back(8'($urandom));
    foreach (table_bytes[i]) archive_bytes.push_back(table_bytes[i]);
  endtask

  // Sends the built archive, sometimes corrupted, cut short or after noise
  task automatic send_variant();
    int kind;
    int idx;
    int keep;
    kind = $urandom_range(0, 9);
    if (kind == 7) begin
      idx = $urandom_range(0, 19);
      if (idx >= 4 && $urandom_range(0, 1) == 1)
        archive_bytes[idx & ~3] = archive_bytes[idx & ~3] | 8'h80;
      else
        archive_bytes[idx] = archive_bytes[idx] ^ 8'($urandom_range(1, 255));
    end else if (kind == 8) begin
      keep = $urandom_range(1, archive_bytes.size());
      while (archive_bytes.size() > keep) void'(archive_bytes.pop_back());
    end else if (kind == 9) begin
      send_noise($urandom_range(3, 20));
    end
    send_archive();
  endtask

  // Result side: random stalls, each accepted transaction goes to the scoreboard
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid)
        sb.check_result(result_t'({out_status, out_path_offset, out_path_length,
                                   out_body_offset, out_body_length}));
    end
  end

  initial begin
    bit [31:0]      need;
    bit [LEN_W-1:0] arc_len;
    bit             fill;
    sb = new();
    gaps_on      = 1'b1;
    bytes_sent   = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_first     <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle byte, too short, bad signature, restart, empty table
    send_byte(8'h00, 1'b0);
    cfg_write('0);
    send_byte(8'hFF, 1'b1);
    cfg_write(LEN_W'(19));
    send_byte(8'hFF, 1'b1);
    send_byte(8'h0E, 1'b0);
    cfg_write(LEN_MAX);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h0E, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h67, 1'b1);
    cfg_write(LEN_W'(MIN_HEADER));
    archive_bytes = '{8'hFF, 8'h0E, 8'h67, 8'h67, 8'h00, 8'h00, 8'h00, 8'h14,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00};
    send_archive();

    // random archives; each group gets its own archive length
    while (bytes_sent < 520) begin
      fill = ($urandom_range(0, 7) == 0);
      build_archive(fill, need);
      if (fill)
        arc_len = LEN_MAX;
      else
        case ($urandom_range(0, 9))
          0:       arc_len = LEN_W'(need - 1);
          1:       arc_len = LEN_W'($urandom_range(0, 19));
          2, 3:    arc_len = LEN_W'(need + $urandom_range(1, 1 << 20));
          default: arc_len = LEN_W'(need);
        endcase
      cfg_write(arc_len);
      gaps_on = (bytes_sent < 470) && ($urandom_range(0, 3) != 0);
      send_variant();
      repeat ($urandom_range(0, 2)) begin
        build_archive(1'b0, need);
        send_variant();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("archive_toc_parser: match");
    else
      $display("archive_toc_parser: mismatch");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("archive_toc_parser: mismatch");
    $finish;
  end

endmodule

[sim.f]
design/atp_pkg.sv
design/atp_core.sv
design/archive_toc_parser.sv
sim/tb.sv
